### src/pseudolocalize_text_stream_core_assert.svh
// assertion macros shared by the rtl files
`ifndef PSEUDOLOCALIZE_TEXT_STREAM_CORE_ASSERT_SVH
`define PSEUDOLOCALIZE_TEXT_STREAM_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PLS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pls_pkg.sv
package pls_pkg;

	// character codes
	localparam logic [7:0] CH_OPEN   = 8'h5B;
	localparam logic [7:0] CH_CLOSE  = 8'h5D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;

	// utf-8 lead and continuation marks
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;
	localparam logic [15:0] UTF_2BYTE_LIMIT = 16'h0800;

	// tilde count: floor(n / 3) as (n * 171) >> 9, exact for 8-bit n
	localparam int          PAD_W      = 7;
	localparam logic [PAD_W-1:0] PAD_MIN = 7'd2;
	localparam logic [16:0] DIV3_MUL   = 17'd171;
	localparam int          DIV3_SHIFT = 9;

	// one classified input word as handed from front to back
	typedef struct packed {
		logic             has_open;
		logic             has_byte;
		logic [1:0]       nbytes;
		logic [2:0][7:0]  bytes;
		logic             has_tail;
		logic [PAD_W-1:0] pad;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_OPEN,
		BK_BODY,
		BK_SPACE,
		BK_TILDE,
		BK_CLOSE
	} back_state_t;

	// accented code points for a..z
	function automatic logic [15:0] lower_cp(input logic [4:0] idx);
		unique case (idx)
			5'd0:  lower_cp = 16'h00E1;
			5'd1:  lower_cp = 16'h0180;
			5'd2:  lower_cp = 16'h00E7;
			5'd3:  lower_cp = 16'h00F0;
			5'd4:  lower_cp = 16'h00E9;
			5'd5:  lower_cp = 16'h0192;
			5'd6:  lower_cp = 16'h011D;
			5'd7:  lower_cp = 16'h0125;
			5'd8:  lower_cp = 16'h00ED;
			5'd9:  lower_cp = 16'h0135;
			5'd10: lower_cp = 16'h0137;
			5'd11: lower_cp = 16'h0142;
			5'd12: lower_cp = 16'h0271;
			5'd13: lower_cp = 16'h00F1;
			5'd14: lower_cp = 16'h00F3;
			5'd15: lower_cp = 16'h00FE;
			5'd16: lower_cp = 16'h01EB;
			5'd17: lower_cp = 16'h0155;
			5'd18: lower_cp = 16'h0161;
			5'd19: lower_cp = 16'h0163;
			5'd20: lower_cp = 16'h00FA;
			5'd21: lower_cp = 16'h0475;
			5'd22: lower_cp = 16'h0175;
			5'd23: lower_cp = 16'h03C7;
			5'd24: lower_cp = 16'h00FD;
			5'd25: lower_cp = 16'h017E;
			default: lower_cp = 16'h00E1;
		endcase
	endfunction

	// accented code points for A..Z
	function automatic logic [15:0] upper_cp(input logic [4:0] idx);
		unique case (idx)
			5'd0:  upper_cp = 16'h00C1;
			5'd1:  upper_cp = 16'h0181;
			5'd2:  upper_cp = 16'h00C7;
			5'd3:  upper_cp = 16'h00D0;
			5'd4:  upper_cp = 16'h00C9;
			5'd5:  upper_cp = 16'h0191;
			5'd6:  upper_cp = 16'h011C;
			5'd7:  upper_cp = 16'h0124;
			5'd8:  upper_cp = 16'h00CD;
			5'd9:  upper_cp = 16'h0134;
			5'd10: upper_cp = 16'h0136;
			5'd11: upper_cp = 16'h0141;
			5'd12: upper_cp = 16'h1E40;
			5'd13: upper_cp = 16'h00D1;
			5'd14: upper_cp = 16'h00D3;
			5'd15: upper_cp = 16'h00DE;
			5'd16: upper_cp = 16'h01EA;
			5'd17: upper_cp = 16'h0154;
			5'd18: upper_cp = 16'h0160;
			5'd19: upper_cp = 16'h0162;
			5'd20: upper_cp = 16'h00DA;
			5'd21: upper_cp = 16'h0474;
			5'd22: upper_cp = 16'h0174;
			5'd23: upper_cp = 16'h03A7;
			5'd24: upper_cp = 16'h00DD;
			5'd25: upper_cp = 16'h017D;
			default: upper_cp = 16'h00C1;
		endcase
	endfunction

endpackage

### src/pls_front.sv
module pls_front import pls_pkg::*; #(
	parameter int MAX_TEXT_LEN = 160
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	input  logic       empty_text,
	input  logic       q_full,
	output logic       q_wr,
	output cmd_t       q_cmd
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_TEXT_LEN);

	logic        inside_q;
	logic [7:0]  seen_q;
	logic        accept;
	logic [7:0]  count_inc;
	logic [7:0]  count_end;
	logic [16:0] prod;
	logic [PAD_W-1:0] pad_raw;
	logic        is_lower;
	logic        is_upper;
	logic [15:0] cp;

	assign full   = q_full;
	assign accept = push & ~q_full;
	assign q_wr   = accept;

	// saturating byte count and tilde count for the text end
	assign count_inc = (seen_q < MAX_LEN) ? seen_q + 8'd1 : seen_q;
	assign count_end = empty_text ? seen_q : count_inc;
	assign prod      = {9'd0, count_end} * DIV3_MUL;
	assign pad_raw   = prod[DIV3_SHIFT +: PAD_W];

	// letter classification and code point lookup
	assign is_lower = (text_byte >= CH_LOW_A) && (text_byte <= CH_LOW_Z);
	assign is_upper = (text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z);
	assign cp = is_lower ? lower_cp(5'(text_byte - CH_LOW_A))
	                     : upper_cp(5'(text_byte - CH_UP_A));

	// build the command word
	always_comb begin
		q_cmd          = '0;
		q_cmd.has_open = (seen_q == 8'd0);
		q_cmd.has_byte = ~empty_text;
		q_cmd.has_tail = empty_text | last_byte;
		q_cmd.pad      = (pad_raw < PAD_MIN) ? PAD_MIN : pad_raw;
		if (!inside_q && (is_lower || is_upper)) begin
			if (cp < UTF_2BYTE_LIMIT) begin
				q_cmd.nbytes   = 2'd2;
				q_cmd.bytes[0] = UTF_LEAD2 | {3'd0, cp[10:6]};
				q_cmd.bytes[1] = UTF_CONT | {2'd0, cp[5:0]};
			end else begin
				q_cmd.nbytes   = 2'd3;
				q_cmd.bytes[0] = UTF_LEAD3 | {4'd0, cp[15:12]};
				q_cmd.bytes[1] = UTF_CONT | {2'd0, cp[11:6]};
				q_cmd.bytes[2] = UTF_CONT | {2'd0, cp[5:0]};
			end
		end else begin
			q_cmd.nbytes   = 2'd1;
			q_cmd.bytes[0] = text_byte;
		end
	end

	// text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			seen_q   <= 8'd0;
		end else if (accept) begin
			if (empty_text || last_byte) begin
				inside_q <= 1'b0;
				seen_q   <= 8'd0;
			end else begin
				seen_q <= count_inc;
				if (text_byte == CH_LBRACE) begin
					inside_q <= 1'b1;
				end else if (text_byte == CH_RBRACE) begin
					inside_q <= 1'b0;
				end
			end
		end
	end

endmodule

### src/pls_queue.sv
`include "pseudolocalize_text_stream_core_assert.svh"

module pls_queue import pls_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd,
	output cmd_t rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_en   = wr & ~full;
	assign rd_en   = rd & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PLS_ASSERT_IMPLY(a_q_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count over depth")
	`PLS_ASSERT_NEXT(a_q_fill, wr_en && !rd_en, count_q == $past(count_q) + 1'b1, "queue fill lost")

endmodule

### src/pls_back.sv
`include "pseudolocalize_text_stream_core_assert.svh"

module pls_back import pls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_cmd,
	output logic       q_rd,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last_out
);

	back_state_t      state_q, state_d;
	cmd_t             cmd_q;
	logic [1:0]       idx_q, idx_d;
	logic [PAD_W-1:0] tcnt_q, tcnt_d;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_out_q;
	logic             adv;
	logic             emit;
	logic [7:0]       emit_byte;
	logic             emit_last;
	logic             done;
	logic             load;

	assign adv      = ~out_valid_q | pop;
	assign empty    = ~out_valid_q;
	assign out_byte = out_byte_q;
	assign last_out = last_out_q;
	assign q_rd     = load;

	// first phase of a fresh word
	function automatic back_state_t first_phase(input cmd_t c);
		if (c.has_open) begin
			first_phase = BK_OPEN;
		end else if (c.has_byte) begin
			first_phase = BK_BODY;
		end else begin
			first_phase = BK_SPACE;
		end
	endfunction

	// sequencer: one output byte per cycle while a word is loaded and the output slot frees
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		tcnt_d    = tcnt_q;
		emit      = 1'b0;
		emit_byte = CH_SPACE;
		emit_last = 1'b0;
		done      = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				load = ~q_empty;
			end
			BK_OPEN: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = CH_OPEN;
					idx_d     = 2'd0;
					state_d   = cmd_q.has_byte ? BK_BODY : BK_SPACE;
				end
			end
			BK_BODY: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = cmd_q.bytes[idx_q];
					if (idx_q == cmd_q.nbytes - 2'd1) begin
						if (cmd_q.has_tail) begin
							state_d = BK_SPACE;
						end else begin
							done = 1'b1;
						end
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			BK_SPACE: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = CH_SPACE;
					tcnt_d    = cmd_q.pad;
					state_d   = BK_TILDE;
				end
			end
			BK_TILDE: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = CH_TILDE;
					if (tcnt_q == PAD_W'(1)) begin
						state_d = BK_CLOSE;
					end else begin
						tcnt_d = tcnt_q - 1'b1;
					end
				end
			end
			BK_CLOSE: begin
				if (adv) begin
					emit      = 1'b1;
					emit_byte = CH_CLOSE;
					emit_last = 1'b1;
					done      = 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		// chain straight into the next word when one waits
		if (done) begin
			load    = ~q_empty;
			state_d = BK_IDLE;
		end
		if (load) begin
			state_d = first_phase(q_cmd);
			idx_d   = 2'd0;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			tcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			tcnt_q  <= tcnt_d;
		end
	end

	// current word
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_cmd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q <= emit_byte;
			last_out_q <= emit_last;
		end
	end

	`PLS_ASSERT_IMPLY(a_tilde_cnt, state_q == BK_TILDE, tcnt_q != '0, "tilde count hit zero")
	`PLS_ASSERT_IMPLY(a_last_close, out_valid_q && last_out_q, out_byte_q == CH_CLOSE, "last not on bracket")

endmodule

### src/pseudolocalize_text_stream_core.sv
// Pseudolocalizing text stream.
// Input channel (push/full): one text byte per word with last_byte marking the
// final byte, or a word with empty_text set that ends the text without a byte.
// Result channel (empty/pop): one UTF-8 byte per word; last_out is set on the
// closing ']' of each text.
// The front classifies each input word in the cycle it is accepted and writes
// a command into a QUEUE_DEPTH entry queue; the back sequencer expands each
// command into 0 to 3 body bytes, plus '[' at text start and ' ', tildes and
// ']' at text end, one byte per cycle into the output register unless pop stalls.
// An item's first byte passes the queue, the back's word register and the
// output register before it is visible. The single output register takes one
// byte per cycle unless pop stalls, and most letters expand to two bytes; the
// front keeps queueing new items while the back expands earlier ones.
// A stalled pop holds the output register; the queue then fills and full
// rises, while words already queued are kept.
// Reset clears the brace flag, byte count, queue and output register.
module pseudolocalize_text_stream_core import pls_pkg::*; #(
	parameter int MAX_TEXT_LEN = 160,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	input  logic       empty_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_out
);

	logic q_wr;
	logic q_full;
	logic q_rd;
	logic q_empty;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	// classify input bytes
	pls_front #(
		.MAX_TEXT_LEN(MAX_TEXT_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.empty_text(empty_text),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_cmd     (wr_cmd)
	);

	// command queue between front and back
	pls_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_data(wr_cmd),
		.full   (q_full),
		.rd     (q_rd),
		.rd_data(rd_cmd),
		.empty  (q_empty)
	);

	// expand commands into output bytes
	pls_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (rd_cmd),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.out_byte(out_byte),
		.last_out(last_out)
	);

endmodule

### test/pseudolocalize_text_stream_core_test.sv
module pseudolocalize_text_stream_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pls_pkg::*;

	localparam int TEXT_LIMIT     = 160;
	localparam int MAX_GAP        = 13;
	localparam int RANDOM_WORDS   = 50;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       ends_text;
	} utf8_word_t;

	// tracks brace and length state, holds the utf-8 words still due
	class text_scoreboard;
		utf8_word_t utf8_due_q[$];
		bit         in_braces;
		bit [7:0]   text_len;
		int         fails;
		bit [15:0]  lower_accent[26];
		bit [15:0]  upper_accent[26];

		function new();
			lower_accent = '{16'h00E1, 16'h0180, 16'h00E7, 16'h00F0, 16'h00E9, 16'h0192,
				16'h011D, 16'h0125, 16'h00ED, 16'h0135, 16'h0137, 16'h0142, 16'h0271,
				16'h00F1, 16'h00F3, 16'h00FE, 16'h01EB, 16'h0155, 16'h0161, 16'h0163,
				16'h00FA, 16'h0475, 16'h0175, 16'h03C7, 16'h00FD, 16'h017E};
			upper_accent = '{16'h00C1, 16'h0181, 16'h00C7, 16'h00D0, 16'h00C9, 16'h0191,
				16'h011C, 16'h0124, 16'h00CD, 16'h0134, 16'h0136, 16'h0141, 16'h1E40,
				16'h00D1, 16'h00D3, 16'h00DE, 16'h01EA, 16'h0154, 16'h0160, 16'h0162,
				16'h00DA, 16'h0474, 16'h0174, 16'h03A7, 16'h00DD, 16'h017D};
			in_braces = 1'b0;
			text_len = 8'd0;
			fails = 0;
		endfunction

		function void add_due(logic [7:0] data, logic ends_text);
			utf8_word_t w;
			w.data = data;
			w.ends_text = ends_text;
			utf8_due_q.insert(utf8_due_q.size(), w);
		endfunction

		// utf-8 encoding of one accented code point
		function void add_code_point(bit [15:0] cp);
			if (cp < 16'h0080) begin
				add_due(cp[7:0], 1'b0);
			end else if (cp < UTF_2BYTE_LIMIT) begin
				add_due(UTF_LEAD2 | {3'b000, cp[10:6]}, 1'b0);
				add_due(UTF_CONT | {2'b00, cp[5:0]}, 1'b0);
			end else begin
				add_due(UTF_LEAD3 | {4'b0000, cp[15:12]}, 1'b0);
				add_due(UTF_CONT | {2'b00, cp[11:6]}, 1'b0);
				add_due(UTF_CONT | {2'b00, cp[5:0]}, 1'b0);
			end
		endfunction

		// closing space, tilde padding and bracket, then a fresh text
		function void add_text_tail();
			int pad;
			pad = text_len / 3;
			if (pad < 2)
				pad = 2;
			add_due(CH_SPACE, 1'b0);
			repeat (pad) add_due(CH_TILDE, 1'b0);
			add_due(CH_CLOSE, 1'b1);
			in_braces = 1'b0;
			text_len = 8'd0;
		endfunction

		// expands one accepted input word into its output words
		function void pseudolocalize_word(logic [7:0] c, logic last_byte, logic empty_text);
			if (empty_text) begin
				if (text_len == 0)
					add_due(CH_OPEN, 1'b0);
				add_text_tail();
				return;
			end
			if (text_len == 0)
				add_due(CH_OPEN, 1'b0);
			if (text_len < TEXT_LIMIT)
				text_len++;
			if (c == CH_LBRACE) begin
				in_braces = 1'b1;
				add_due(c, 1'b0);
			end else if (c == CH_RBRACE) begin
				in_braces = 1'b0;
				add_due(c, 1'b0);
			end else if (in_braces) begin
				add_due(c, 1'b0);
			end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
				add_code_point(lower_accent[c - CH_LOW_A]);
			end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
				add_code_point(upper_accent[c - CH_UP_A]);
			end else begin
				add_due(c, 1'b0);
			end
			if (last_byte)
				add_text_tail();
		endfunction

		// compares one popped word with the oldest due word
		function void check_utf8_word(logic [7:0] data, logic ends_text);
			utf8_word_t w;
			if (utf8_due_q.size() == 0) begin
				$error("unexpected word: out_byte %h last_out %b", data, ends_text);
				fails++;
				return;
			end
			w = utf8_due_q.pop_front();
			if (data !== w.data) begin
				$error("out_byte expected %h actual %h", w.data, data);
				fails++;
			end
			if (ends_text !== w.ends_text) begin
				$error("last_out expected %b actual %b", w.ends_text, ends_text);
				fails++;
			end
		endfunction

		function int words_due();
			return utf8_due_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] text_byte;
	logic       last_byte;
	logic       empty_text;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       last_out;

	text_scoreboard sb = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int words_sent = 0;
	int idle_cycles = 0;

	pseudolocalize_text_stream_core #(
		.MAX_TEXT_LEN(TEXT_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.last_byte(last_byte),
		.empty_text(empty_text),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last_out(last_out)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("pseudolocalize_text_stream_core: mismatch");
			$finish;
		end
	end

	// sends one input word, after a random gap while tx_idle is set, returns once accepted
	task automatic send_word(input logic [7:0] c, input logic lb, input logic et);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		text_byte <= c;
		last_byte <= lb;
		empty_text <= et;
		do @(posedge clk); while (full);
		sb.pseudolocalize_word(c, lb, et);
		words_sent++;
		if ($urandom_range(0, 39) == 0)
			tx_idle = !tx_idle;
	endtask

	task automatic send_chars(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], close && (i == s.len() - 1), 1'b0);
	endtask

	// mostly letters and braces, the rest any byte value
	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'(CH_LOW_A + $urandom_range(0, 25));
			4, 5:       return 8'(CH_UP_A + $urandom_range(0, 25));
			6:          return CH_LBRACE;
			7:          return CH_RBRACE;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one text of len bytes, closed by last_byte or by an empty-flag word
	task automatic send_text(input int len, input bit close_by_empty);
		for (int i = 0; i < len; i++)
			send_word(pick_text_byte(), (i == len - 1) && !close_by_empty, 1'b0);
		if (close_by_empty || len == 0)
			send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	// drop push, then hold off until every due word has been popped
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (sb.words_due() != 0) @(posedge clk);
	endtask

	// result side: random stalls, check each popped word
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_utf8_word(out_byte, last_out);
			if ($urandom_range(0, 49) == 0)
				rx_idle = !rx_idle;
		end
	end

	// reset, directed texts, random texts, drain
	initial begin
		int start_words;
		bit drained_once;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		text_byte = 8'h00;
		last_byte = 1'b0;
		empty_text = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty texts, one with every other field set
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hFF, 1'b1, 1'b1);
		// letter extremes, three-byte code point, brace passthrough, range edges
		send_chars("azAZMmvX{qQ", 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(CH_RBRACE, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b0);
		// text ending inside braces; next text must map letters again
		send_chars("@`[{", 1'b1);
		send_chars("b", 1'b1);
		// empty flag ends a text mid-way
		send_chars("cd", 1'b0);
		send_word(CH_LBRACE, 1'b1, 1'b1);
		wait_drained();

		// long text past the length limit
		send_text($urandom_range(TEXT_LIMIT + 2, TEXT_LIMIT + 12), 1'($urandom_range(0, 1)));

		start_words = words_sent;
		drained_once = 1'b0;
		while (words_sent - start_words < RANDOM_WORDS) begin
			if (!drained_once && words_sent - start_words > RANDOM_WORDS / 2) begin
				wait_drained();
				drained_once = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				send_text($urandom_range(20, 40), $urandom_range(0, 5) == 0);
			else
				send_text($urandom_range(0, 12), $urandom_range(0, 5) == 0);
		end
		@(negedge clk);
		push <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("pseudolocalize_text_stream_core: match");
		else
			$display("pseudolocalize_text_stream_core: mismatch");
		$finish;
	end

endmodule
